// ===== rtl/core/iscr_pkg.sv =====
// ----------------------------------------------------------------------------
// iscr_pkg: shared types and constants for the interval/stride resolver
// Word widths, constraint and status codes, transaction payloads, and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package iscr_pkg;

    localparam int WORD_BITS      = 64;
    localparam int MOD_LIMIT_BITS = 36;
    localparam int ID_BITS        = 16;
    localparam int CONF_BITS      = 3;
    localparam int QTY_BITS       = 6;
    localparam int OPC_BITS       = 3;
    localparam int STAT_BITS      = 2;
    localparam int CFG_DATA_BITS  = 6;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CNT_BITS       = $clog2(WORD_BITS + 1);

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX  = '1;
    localparam word_t MOD_LIMIT = (word_t'(1) << MOD_LIMIT_BITS) - word_t'(1);

    // constraint codes
    localparam logic [OPC_BITS-1:0] COP_LOWER   = 3'd0;
    localparam logic [OPC_BITS-1:0] COP_UPPER   = 3'd1;
    localparam logic [OPC_BITS-1:0] COP_EQUAL   = 3'd2;
    localparam logic [OPC_BITS-1:0] COP_EXCLUDE = 3'd3;
    localparam logic [OPC_BITS-1:0] COP_STRIDE  = 3'd4;

    // result status codes
    localparam logic [STAT_BITS-1:0] STS_SKIP     = 2'd0;
    localparam logic [STAT_BITS-1:0] STS_ACCEPT   = 2'd1;
    localparam logic [STAT_BITS-1:0] STS_CONFLICT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR  = 1'd1;

    typedef struct packed {
        logic                 start_new;
        logic [QTY_BITS-1:0]  quantity;
        logic [OPC_BITS-1:0]  constraint_op;
        word_t                value;
        word_t                value2;
        logic [ID_BITS-1:0]   constraint_id;
        logic [CONF_BITS-1:0] confidence;
    } req_t;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        word_t                lower_out;
        word_t                upper_out;
        word_t                modulus_out;
        word_t                residue_out;
        logic [ID_BITS-1:0]   lower_binder;
        logic [ID_BITS-1:0]   upper_binder;
        logic [ID_BITS-1:0]   modulus_binder;
        logic [CONF_BITS-1:0] lower_trust;
        logic [CONF_BITS-1:0] upper_trust;
    } rsp_t;

    // divider operand pairs
    typedef enum logic [3:0] {
        DV_V_V2, DV_GCD, DV_R1_G, DV_R2_G, DV_M1_G, DV_M2_G, DV_DIFF_G,
        DV_Q_N, DV_M1_N, DV_A_N, DV_EU, DV_OLDS_N, DV_LO_MOD
    } div_sel_t;

    // multiplier operand pairs
    typedef enum logic [1:0] {
        MU_A_M2, MU_QS, MU_M1_T
    } mul_sel_t;

    // datapath register transfers
    typedef enum logic [4:0] {
        DP_NONE, DP_SKIP, DP_TRIAL, DP_TK_FIRST, DP_TK_R2, DP_TK_GCD,
        DP_TK_RG1, DP_TK_A, DP_TK_AM2, DP_TK_N, DP_TK_Q1, DP_TK_D, DP_TK_Z,
        DP_TK_INVARG, DP_TK_EUQ, DP_TK_EUS, DP_FIX, DP_TK_INV, DP_MM_STEP,
        DP_TK_RR, DP_COMMIT, DP_TK_EMPTY, DP_CONFLICT, DP_OUT
    } dp_op_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     mul_start;
        mul_sel_t mul_sel;
        dp_op_t   op;
    } cmd_t;

    typedef struct packed {
        logic scope_ok;
        logic stride_ok;
        logic mod_zero;
        logic tmod_zero;
        logic div_done;
        logic mul_done;
        logic rem_zero;
        logic rem_mismatch;
        logic mul_ovf;
        logic tmp_zero;
        logic mmb_zero;
    } stat_t;

endpackage

// ===== rtl/core/iscr_req_if.sv =====
// ----------------------------------------------------------------------------
// iscr_req_if: constraint channel
// Valid/ready channel carrying one constraint per transaction.
// ----------------------------------------------------------------------------
interface iscr_req_if;
    import iscr_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/iscr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// iscr_rsp_if: result channel
// Valid/ready channel carrying one estimate snapshot per transaction.
// ----------------------------------------------------------------------------
interface iscr_rsp_if;
    import iscr_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/interval_stride_constraint_resolver_unit.sv =====
// A skipped constraint goes straight to the result; a bound, equal or exclude
//   constraint with a stride class adds one division for the emptiness test.
// Each division or multiplication runs on the shared 64-bit shift-subtract and
//   shift-add units; a stride fold chains divisions and multiplications over its
//   gcd steps and Euclid steps, then one modular step per inverse bit.
// One constraint at a time; the next is accepted the cycle after the result loads.
// Reset: estimate to full range with no stride, bindings and registers zero.
// ----------------------------------------------------------------------------
// interval_stride_constraint_resolver_unit: interval and stride resolver
// Applies prioritized constraints to an interval with a congruence class and
// returns the estimate after each constraint.
// ----------------------------------------------------------------------------
module interval_stride_constraint_resolver_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [iscr_pkg::CFG_IDX_BITS-1:0]  wr_index,
    input  logic [iscr_pkg::CFG_DATA_BITS-1:0] wr_data,
    iscr_req_if.sink                           req,
    iscr_rsp_if.source                         rsp
);
    import iscr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    iscr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    iscr_dpath u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_data (req.payload),
        .rsp_data (rsp.payload),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

endmodule

// ===== rtl/core/iscr_div.sv =====
// ----------------------------------------------------------------------------
// iscr_div: sequential unsigned divider
// Restoring shift-and-subtract, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iscr_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  iscr_pkg::word_t dividend,
    input  iscr_pkg::word_t divisor,
    output logic            done,
    output iscr_pkg::word_t quo,
    output iscr_pkg::word_t rem
);
    import iscr_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    word_t               quo_reg;
    word_t               rem_reg;
    word_t               dsr_reg;

    logic [WORD_BITS:0]  shifted;
    logic [WORD_BITS:0]  diff;
    logic                fits;
    word_t               rem_next;
    word_t               quo_next;

    // one restoring step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[WORD_BITS-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        quo_next = {quo_reg[WORD_BITS-2:0], fits};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WORD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/iscr_mul.sv =====
// ----------------------------------------------------------------------------
// iscr_mul: sequential unsigned multiplier
// Shift-and-add, one multiplier bit per cycle, full double-width product.
// ----------------------------------------------------------------------------
module iscr_mul
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  iscr_pkg::word_t mcand,
    input  iscr_pkg::word_t mplier,
    output logic            done,
    output iscr_pkg::word_t lo,
    output iscr_pkg::word_t hi
);
    import iscr_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    word_t                  mcand_reg;
    logic [2*WORD_BITS-1:0] prod_reg;

    logic [WORD_BITS:0]     sum;
    logic [2*WORD_BITS-1:0] prod_next;

    // add the multiplicand into the upper half, then shift right
    always_comb
    begin
        sum       = {1'b0, prod_reg[2*WORD_BITS-1:WORD_BITS]}
                  + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {sum, prod_reg[WORD_BITS-1:1]};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WORD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            prod_reg  <= {{WORD_BITS{1'b0}}, mplier};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign lo   = prod_reg[WORD_BITS-1:0];
    assign hi   = prod_reg[2*WORD_BITS-1:WORD_BITS];

endmodule

// ===== rtl/core/iscr_dpath.sv =====
// ----------------------------------------------------------------------------
// iscr_dpath: resolver datapath
// Configuration, estimate and trial registers, the scratch registers of the
// stride fold, and the shared divider and multiplier.
// ----------------------------------------------------------------------------
module iscr_dpath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  iscr_pkg::cmd_t                     cmd,
    output iscr_pkg::stat_t                    stat,
    input  iscr_pkg::req_t                     req_data,
    output iscr_pkg::rsp_t                     rsp_data,
    input  logic                               wr_en,
    input  logic [iscr_pkg::CFG_IDX_BITS-1:0]  wr_index,
    input  logic [iscr_pkg::CFG_DATA_BITS-1:0] wr_data
);
    import iscr_pkg::*;

    // (x + y) mod n for x, y < n
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t n);
        word_t ny;
        begin
            ny      = n - y;
            add_mod = (x >= ny) ? x - ny : x + y;
        end
    endfunction

    // configuration
    logic [QTY_BITS-1:0]  tq_reg;
    logic [CONF_BITS-1:0] floor_reg;

    // captured constraint
    req_t cap_reg;

    // committed estimate
    word_t                st_lo_reg, st_hi_reg, st_mod_reg, st_res_reg;
    logic [ID_BITS-1:0]   st_lbind_reg, st_hbind_reg, st_mbind_reg;
    logic [CONF_BITS-1:0] st_lconf_reg, st_hconf_reg;

    // trial estimate
    word_t                tr_lo_reg, tr_hi_reg, tr_mod_reg, tr_res_reg;
    logic [ID_BITS-1:0]   tr_lbind_reg, tr_hbind_reg, tr_mbind_reg;
    logic [CONF_BITS-1:0] tr_lconf_reg, tr_hconf_reg;

    // fold scratch
    word_t r1_reg, r2_reg, m1_reg, m2_reg, ga_reg, gb_reg, a_reg, mm_reg;
    word_t n_reg, tmp_reg, d_reg, oldr_reg, eur_reg, olds_reg, s_reg, q_reg;
    word_t mma_reg, mmb_reg, mmr_reg;

    logic [STAT_BITS-1:0] status_reg;
    rsp_t                 out_reg;

    // units
    word_t div_a, div_b, div_quo, div_rem;
    word_t mul_a, mul_b, mul_lo, mul_hi;
    logic  div_done, mul_done;

    // combinational helpers
    word_t cv, cv2;
    logic  lset, hset;
    word_t tl, th;
    logic  r2_ge;
    word_t diff;
    word_t s_mag;
    word_t prod_s;
    word_t addv;
    logic  empty;
    logic  commit_ok;

    assign cv  = cap_reg.value;
    assign cv2 = cap_reg.value2;

    // trial interval edges for bound, equality and exclusion constraints
    always_comb
    begin
        tl   = st_lo_reg;
        th   = st_hi_reg;
        lset = 1'b0;
        hset = 1'b0;
        if ((cap_reg.constraint_op == COP_LOWER || cap_reg.constraint_op == COP_EQUAL)
            && cv > st_lo_reg)
        begin
            tl   = cv;
            lset = 1'b1;
        end
        if ((cap_reg.constraint_op == COP_UPPER || cap_reg.constraint_op == COP_EQUAL)
            && cv < st_hi_reg)
        begin
            th   = cv;
            hset = 1'b1;
        end
        if (cap_reg.constraint_op == COP_EXCLUDE)
        begin
            if (cv <= st_lo_reg && cv2 >= st_lo_reg && cv2 < st_hi_reg)
            begin
                tl   = cv2 + word_t'(1);
                lset = 1'b1;
            end
            else if (cv2 >= st_hi_reg && cv <= st_hi_reg && cv > st_lo_reg)
            begin
                th   = cv - word_t'(1);
                hset = 1'b1;
            end
        end
    end

    // fold helpers and emptiness test
    always_comb
    begin
        r2_ge  = r2_reg >= r1_reg;
        diff   = r2_ge ? r2_reg - r1_reg : r1_reg - r2_reg;
        s_mag  = s_reg[WORD_BITS-1] ? word_t'(-s_reg) : s_reg;
        prod_s = s_reg[WORD_BITS-1] ? word_t'(-mul_lo) : mul_lo;
        addv   = (tr_res_reg >= div_rem) ? tr_res_reg - div_rem
                                         : tr_mod_reg - (div_rem - tr_res_reg);
        empty  = (tr_lo_reg > tr_hi_reg) || (tr_lo_reg > WORD_MAX - addv)
              || (tr_lo_reg + addv > tr_hi_reg);
        commit_ok = ((cmd.op == DP_COMMIT) && !(tr_lo_reg > tr_hi_reg))
                 || ((cmd.op == DP_TK_EMPTY) && !empty);
    end

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DV_V_V2:   begin div_a = cv;        div_b = cv2;        end
            DV_GCD:    begin div_a = ga_reg;    div_b = gb_reg;     end
            DV_R1_G:   begin div_a = r1_reg;    div_b = ga_reg;     end
            DV_R2_G:   begin div_a = r2_reg;    div_b = ga_reg;     end
            DV_M1_G:   begin div_a = m1_reg;    div_b = ga_reg;     end
            DV_M2_G:   begin div_a = m2_reg;    div_b = ga_reg;     end
            DV_DIFF_G: begin div_a = diff;      div_b = ga_reg;     end
            DV_Q_N:    begin div_a = tmp_reg;   div_b = n_reg;      end
            DV_M1_N:   begin div_a = m1_reg;    div_b = n_reg;      end
            DV_A_N:    begin div_a = a_reg;     div_b = n_reg;      end
            DV_EU:     begin div_a = oldr_reg;  div_b = eur_reg;    end
            DV_OLDS_N: begin div_a = olds_reg;  div_b = n_reg;      end
            DV_LO_MOD: begin div_a = tr_lo_reg; div_b = tr_mod_reg; end
            default:   begin div_a = cv;        div_b = cv2;        end
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MU_A_M2: begin mul_a = a_reg;  mul_b = m2_reg;  end
            MU_QS:   begin mul_a = q_reg;  mul_b = s_mag;   end
            MU_M1_T: begin mul_a = m1_reg; mul_b = mmr_reg; end
            default: begin mul_a = a_reg;  mul_b = m2_reg;  end
        endcase
    end

    iscr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    iscr_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .lo     (mul_lo),
        .hi     (mul_hi)
    );

    // configuration, estimate and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tq_reg       <= '0;
            floor_reg    <= '0;
            st_lo_reg    <= '0;
            st_hi_reg    <= WORD_MAX;
            st_mod_reg   <= '0;
            st_res_reg   <= '0;
            st_lbind_reg <= '0;
            st_hbind_reg <= '0;
            st_mbind_reg <= '0;
            st_lconf_reg <= '0;
            st_hconf_reg <= '0;
            status_reg   <= STS_SKIP;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_TARGET)
                    tq_reg <= wr_data[QTY_BITS-1:0];
                else if (wr_index == REG_FLOOR)
                    floor_reg <= wr_data[CONF_BITS-1:0];
            end

            if (cmd.load && req_data.start_new)
            begin
                st_lo_reg    <= '0;
                st_hi_reg    <= WORD_MAX;
                st_mod_reg   <= '0;
                st_res_reg   <= '0;
                st_lbind_reg <= '0;
                st_hbind_reg <= '0;
                st_mbind_reg <= '0;
                st_lconf_reg <= '0;
                st_hconf_reg <= '0;
            end
            else if (commit_ok)
            begin
                st_lo_reg    <= tr_lo_reg;
                st_hi_reg    <= tr_hi_reg;
                st_mod_reg   <= tr_mod_reg;
                st_res_reg   <= tr_res_reg;
                st_lbind_reg <= tr_lbind_reg;
                st_hbind_reg <= tr_hbind_reg;
                st_mbind_reg <= tr_mbind_reg;
                st_lconf_reg <= tr_lconf_reg;
                st_hconf_reg <= tr_hconf_reg;
            end

            case (cmd.op)
                DP_SKIP:     status_reg <= STS_SKIP;
                DP_CONFLICT: status_reg <= STS_CONFLICT;
                DP_COMMIT, DP_TK_EMPTY:
                    status_reg <= commit_ok ? STS_ACCEPT : STS_CONFLICT;
                default:     status_reg <= status_reg;
            endcase
        end
    end

    // capture, trial and fold scratch registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            cap_reg <= req_data;

        case (cmd.op)
            DP_TRIAL:
            begin
                tr_lo_reg    <= tl;
                tr_hi_reg    <= th;
                tr_mod_reg   <= st_mod_reg;
                tr_res_reg   <= st_res_reg;
                tr_mbind_reg <= st_mbind_reg;
                tr_lbind_reg <= lset ? cap_reg.constraint_id : st_lbind_reg;
                tr_lconf_reg <= lset ? cap_reg.confidence : st_lconf_reg;
                tr_hbind_reg <= hset ? cap_reg.constraint_id : st_hbind_reg;
                tr_hconf_reg <= hset ? cap_reg.confidence : st_hconf_reg;
                r1_reg       <= st_res_reg;
                m1_reg       <= st_mod_reg;
                m2_reg       <= cv2;
                ga_reg       <= st_mod_reg;
                gb_reg       <= cv2;
            end
            DP_TK_FIRST:
            begin
                tr_mod_reg   <= cv2;
                tr_res_reg   <= div_rem;
                tr_mbind_reg <= cap_reg.constraint_id;
            end
            DP_TK_R2:  r2_reg <= div_rem;
            DP_TK_GCD:
            begin
                ga_reg <= gb_reg;
                gb_reg <= div_rem;
            end
            DP_TK_RG1: tmp_reg <= div_rem;
            DP_TK_A:   a_reg   <= div_quo;
            DP_TK_AM2: mm_reg  <= mul_lo;
            DP_TK_N:   n_reg   <= div_quo;
            DP_TK_Q1:  tmp_reg <= div_quo;
            DP_TK_D:
            begin
                if (r2_ge)
                    d_reg <= div_rem;
                else
                    d_reg <= (div_rem == '0) ? '0 : n_reg - div_rem;
            end
            DP_TK_Z:   tmp_reg <= div_rem;
            DP_TK_INVARG:
            begin
                oldr_reg <= (tmp_reg == '0) ? '0 : div_rem;
                eur_reg  <= n_reg;
                olds_reg <= word_t'(1);
                s_reg    <= '0;
            end
            DP_TK_EUQ:
            begin
                q_reg   <= div_quo;
                tmp_reg <= div_rem;
            end
            DP_TK_EUS:
            begin
                oldr_reg <= eur_reg;
                eur_reg  <= tmp_reg;
                olds_reg <= s_reg;
                s_reg    <= olds_reg - prod_s;
            end
            DP_FIX:
            begin
                if (olds_reg[WORD_BITS-1])
                    olds_reg <= olds_reg + n_reg;
            end
            DP_TK_INV:
            begin
                mma_reg <= d_reg;
                mmb_reg <= div_rem;
                mmr_reg <= '0;
            end
            DP_MM_STEP:
            begin
                if (mmb_reg[0])
                    mmr_reg <= add_mod(mmr_reg, mma_reg, n_reg);
                mma_reg <= add_mod(mma_reg, mma_reg, n_reg);
                mmb_reg <= mmb_reg >> 1;
            end
            DP_TK_RR:
            begin
                tr_mod_reg   <= mm_reg;
                tr_res_reg   <= r1_reg + mul_lo;
                tr_mbind_reg <= cap_reg.constraint_id;
            end
            DP_OUT:
            begin
                out_reg.status         <= status_reg;
                out_reg.lower_out      <= st_lo_reg;
                out_reg.upper_out      <= st_hi_reg;
                out_reg.modulus_out    <= st_mod_reg;
                out_reg.residue_out    <= st_res_reg;
                out_reg.lower_binder   <= st_lbind_reg;
                out_reg.upper_binder   <= st_hbind_reg;
                out_reg.modulus_binder <= st_mbind_reg;
                out_reg.lower_trust    <= st_lconf_reg;
                out_reg.upper_trust    <= st_hconf_reg;
            end
            default:
            begin
            end
        endcase
    end

    // status to the controller
    always_comb
    begin
        stat.scope_ok     = (cap_reg.quantity == tq_reg) && (cap_reg.confidence >= floor_reg);
        stat.stride_ok    = (cap_reg.constraint_op == COP_STRIDE) && (cv2 != '0)
                         && (cv2 <= MOD_LIMIT);
        stat.mod_zero     = st_mod_reg == '0;
        stat.tmod_zero    = tr_mod_reg == '0;
        stat.div_done     = div_done;
        stat.mul_done     = mul_done;
        stat.rem_zero     = div_rem == '0;
        stat.rem_mismatch = div_rem != tmp_reg;
        stat.mul_ovf      = mul_hi != '0;
        stat.tmp_zero     = tmp_reg == '0;
        stat.mmb_zero     = mmb_reg == '0;
    end

    assign rsp_data = out_reg;

endmodule

// ===== rtl/core/iscr_ctrl.sv =====
// ----------------------------------------------------------------------------
// iscr_ctrl: resolver controller
// Sequences the trial, the stride fold (gcd, class check, extended Euclid,
// modular product) and the emptiness test, and owns both handshakes.
// ----------------------------------------------------------------------------
module iscr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output iscr_pkg::cmd_t  cmd,
    input  iscr_pkg::stat_t stat
);
    import iscr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SCOPE, S_FIRST, S_R2, S_GCD, S_RG1, S_RG2, S_A, S_AM2, S_N,
        S_Q1, S_D, S_Z, S_INVARG, S_EUQ, S_EUS, S_FIX, S_INV, S_MM, S_RR,
        S_CHECK, S_EMPTY, S_CONFLICT, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   started_reg, started_next;
    logic   out_valid_reg, out_valid_next;

    // next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        cmd          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCOPE;
                end
            end
            S_SCOPE:
            begin
                if (!stat.scope_ok)
                begin
                    cmd.op     = DP_SKIP;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op = DP_TRIAL;
                    if (!stat.stride_ok)
                        state_next = S_CHECK;
                    else if (stat.mod_zero)
                        state_next = S_FIRST;
                    else
                        state_next = S_R2;
                end
            end
            S_FIRST, S_R2, S_GCD, S_RG1, S_RG2, S_A, S_N, S_Q1, S_D, S_Z,
            S_INVARG, S_EUQ, S_INV, S_EMPTY:
            begin
                // divider steps: launch, then take the result
                if (!started_reg)
                begin
                    started_next  = 1'b1;
                    cmd.div_start = 1'b1;
                    case (state_reg)
                        S_FIRST, S_R2: cmd.div_sel = DV_V_V2;
                        S_GCD:         cmd.div_sel = DV_GCD;
                        S_RG1:         cmd.div_sel = DV_R1_G;
                        S_RG2:         cmd.div_sel = DV_R2_G;
                        S_A:           cmd.div_sel = DV_M1_G;
                        S_N:           cmd.div_sel = DV_M2_G;
                        S_Q1:          cmd.div_sel = DV_DIFF_G;
                        S_D:           cmd.div_sel = DV_Q_N;
                        S_Z:           cmd.div_sel = DV_M1_N;
                        S_INVARG:      cmd.div_sel = DV_A_N;
                        S_EUQ:         cmd.div_sel = DV_EU;
                        S_INV:         cmd.div_sel = DV_OLDS_N;
                        default:       cmd.div_sel = DV_LO_MOD;
                    endcase
                end
                else if (stat.div_done)
                begin
                    started_next = 1'b0;
                    case (state_reg)
                        S_FIRST:  begin cmd.op = DP_TK_FIRST;  state_next = S_CHECK;  end
                        S_R2:     begin cmd.op = DP_TK_R2;     state_next = S_GCD;    end
                        S_GCD:
                        begin
                            cmd.op = DP_TK_GCD;
                            if (stat.rem_zero)
                                state_next = S_RG1;
                        end
                        S_RG1:    begin cmd.op = DP_TK_RG1;    state_next = S_RG2;    end
                        S_RG2:    state_next = stat.rem_mismatch ? S_CONFLICT : S_A;
                        S_A:      begin cmd.op = DP_TK_A;      state_next = S_AM2;    end
                        S_N:      begin cmd.op = DP_TK_N;      state_next = S_Q1;     end
                        S_Q1:     begin cmd.op = DP_TK_Q1;     state_next = S_D;      end
                        S_D:      begin cmd.op = DP_TK_D;      state_next = S_Z;      end
                        S_Z:      begin cmd.op = DP_TK_Z;      state_next = S_INVARG; end
                        S_INVARG: begin cmd.op = DP_TK_INVARG; state_next = S_EUQ;    end
                        S_EUQ:    begin cmd.op = DP_TK_EUQ;    state_next = S_EUS;    end
                        S_INV:    begin cmd.op = DP_TK_INV;    state_next = S_MM;     end
                        default:  begin cmd.op = DP_TK_EMPTY;  state_next = S_FINISH; end
                    endcase
                end
            end
            S_AM2, S_EUS, S_RR:
            begin
                // multiplier steps
                if (!started_reg)
                begin
                    started_next  = 1'b1;
                    cmd.mul_start = 1'b1;
                    case (state_reg)
                        S_AM2:   cmd.mul_sel = MU_A_M2;
                        S_EUS:   cmd.mul_sel = MU_QS;
                        default: cmd.mul_sel = MU_M1_T;
                    endcase
                end
                else if (stat.mul_done)
                begin
                    started_next = 1'b0;
                    case (state_reg)
                        S_AM2:
                        begin
                            cmd.op     = DP_TK_AM2;
                            state_next = stat.mul_ovf ? S_CONFLICT : S_N;
                        end
                        S_EUS:
                        begin
                            cmd.op     = DP_TK_EUS;
                            state_next = stat.tmp_zero ? S_FIX : S_EUQ;
                        end
                        default:
                        begin
                            cmd.op     = DP_TK_RR;
                            state_next = S_CHECK;
                        end
                    endcase
                end
            end
            S_FIX:
            begin
                cmd.op     = DP_FIX;
                state_next = S_INV;
            end
            S_MM:
            begin
                if (stat.mmb_zero)
                    state_next = S_RR;
                else
                    cmd.op = DP_MM_STEP;
            end
            S_CHECK:
            begin
                if (stat.tmod_zero)
                begin
                    cmd.op     = DP_COMMIT;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_EMPTY;
                end
            end
            S_CONFLICT:
            begin
                cmd.op     = DP_CONFLICT;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid
    always_comb
    begin
        if (cmd.op == DP_OUT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule
